@@ rtl/first_fit_run_slot_allocator_assert.svh @@
// assertion macros used by the allocator rtl
`ifndef FIRST_FIT_RUN_SLOT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_RUN_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFRSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ffrsa same-cycle check failed");

// next-cycle implication
`define FFRSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ffrsa next-cycle check failed");

`endif

@@ rtl/ffrsa_pkg.sv @@
package ffrsa_pkg;

	localparam int ROW_W     = 3;
	localparam int SLOT_W    = 3;
	localparam int ID_W      = 16;
	localparam int CNT_OUT_W = 4;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	localparam logic RUN_SINGLE = 1'b0;
	localparam logic RUN_MULTI  = 1'b1;

endpackage

@@ rtl/first_fit_run_slot_allocator.sv @@
// First-fit slot allocator over a square grid of SLOTS rows of SLOTS slots. A beat is
// taken when start is high and busy is low; its result comes back as a one-cycle done
// strobe with granted, got_row, got_slot and row_free_count, and must be captured then.
// An allocate reads one row a cycle from the row memory (occupancy map and free count)
// and checks it the cycle after; the first row with a fit then writes the owner id into
// its slot, or into each slot of a run of RUN_LENGTH (one owner id is written per cycle),
// before it reports; if no row fits, it reports once the last row is checked. A release
// goes through read, update and write back; a release of a row outside the grid reports
// on the next cycle. busy stays high until the done cycle, and a new beat may start then.
`include "first_fit_run_slot_allocator_assert.svh"

module first_fit_run_slot_allocator
	import ffrsa_pkg::*;
#(
	parameter int SLOTS      = 8,
	parameter int RUN_LENGTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 req_type,
	input  logic                 run_kind,
	input  logic [ID_W-1:0]      owner_id,
	input  logic [ROW_W-1:0]     row_index,
	input  logic [SLOT_W-1:0]    start_slot,
	output logic                 done,
	output logic                 granted,
	output logic [ROW_W-1:0]     got_row,
	output logic [SLOT_W-1:0]    got_slot,
	output logic [CNT_OUT_W-1:0] row_free_count
);

	localparam int RW = $clog2(SLOTS);
	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int KW = $clog2(RUN_LENGTH);
	localparam int AW = $clog2(SLOTS * SLOTS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	state_t               state_q;
	logic                 req_release_q;
	logic                 req_run_q;
	logic [ID_W-1:0]      owner_q;
	logic [SLOT_W-1:0]    rel_start_q;
	logic [RW-1:0]        scan_row_q;
	logic                 issue_q;
	logic                 chk_vld_s1;
	logic [RW-1:0]        chk_row_s1;
	logic [RW-1:0]        wr_row_q;
	logic [SW-1:0]        wr_slot_q;
	logic [SLOTS-1:0]     wr_occ_q;
	logic [CW-1:0]        wr_cnt_q;
	logic [KW-1:0]        k_q;
	logic                 done_q;
	logic                 granted_q;
	logic [ROW_W-1:0]     got_row_q;
	logic [SLOT_W-1:0]    got_slot_q;
	logic [CNT_OUT_W-1:0] cnt_out_q;

	logic                 rd_en;
	logic [SLOTS-1:0]     rd_occ;
	logic [CW-1:0]        rd_cnt;
	logic                 row_wr_en;
	logic                 own_wr_en;
	logic [AW-1:0]        own_wr_addr;
	logic                 fit_hit;
	logic [SW-1:0]        fit_slot;
	logic [SLOTS-1:0]     new_occ;
	logic [CW-1:0]        new_cnt;
	logic                 wr_last;
	logic                 row_in_range;

	assign rd_en     = (state_q == ST_SCAN) && issue_q;
	assign row_wr_en = (state_q == ST_WRITE) && (k_q == '0);
	assign own_wr_en = (state_q == ST_WRITE) && (req_release_q == REQ_ALLOC);
	assign own_wr_addr = AW'(int'(wr_row_q) * SLOTS + int'(wr_slot_q) + int'(k_q));
	assign wr_last = (req_release_q == REQ_RELEASE) || (req_run_q == RUN_SINGLE)
		|| (k_q == KW'(RUN_LENGTH - 1));
	assign row_in_range = int'(row_index) < SLOTS;

	ffrsa_row_mem #(
		.SLOTS (SLOTS)
	) u_row_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (scan_row_q),
		.rd_occ  (rd_occ),
		.rd_cnt  (rd_cnt),
		.wr_en   (row_wr_en),
		.wr_addr (wr_row_q),
		.wr_occ  (wr_occ_q),
		.wr_cnt  (wr_cnt_q)
	);

	ffrsa_owner_mem #(
		.DEPTH (SLOTS * SLOTS)
	) u_owner_mem (
		.clk     (clk),
		.wr_en   (own_wr_en),
		.wr_addr (own_wr_addr),
		.wr_id   (owner_q)
	);

	ffrsa_fit #(
		.SLOTS      (SLOTS),
		.RUN_LENGTH (RUN_LENGTH)
	) u_fit (
		.occ      (rd_occ),
		.run_kind (req_run_q),
		.hit      (fit_hit),
		.slot     (fit_slot)
	);

	// row update: set or clear the run, saturating free count
	always_comb begin
		int len;
		int base;
		int sum;
		len  = (req_run_q == RUN_MULTI) ? RUN_LENGTH : 1;
		base = (req_release_q == REQ_RELEASE) ? int'(rel_start_q) : int'(fit_slot);
		sum  = int'(rd_cnt) + len;
		for (int s = 0; s < SLOTS; s++) begin
			if (s >= base && s < base + len) begin
				new_occ[s] = (req_release_q == REQ_ALLOC);
			end else begin
				new_occ[s] = rd_occ[s];
			end
		end
		if (req_release_q == REQ_RELEASE) begin
			new_cnt = (sum > SLOTS) ? CW'(SLOTS) : CW'(sum);
		end else begin
			new_cnt = (int'(rd_cnt) > len) ? CW'(int'(rd_cnt) - len) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			req_release_q <= REQ_ALLOC;
			req_run_q     <= RUN_SINGLE;
			owner_q       <= '0;
			rel_start_q   <= '0;
			scan_row_q    <= '0;
			issue_q       <= 1'b0;
			chk_vld_s1    <= 1'b0;
			chk_row_s1    <= '0;
			wr_row_q      <= '0;
			wr_slot_q     <= '0;
			wr_occ_q      <= '0;
			wr_cnt_q      <= '0;
			k_q           <= '0;
			done_q        <= 1'b0;
			granted_q     <= 1'b0;
			got_row_q     <= '0;
			got_slot_q    <= '0;
			cnt_out_q     <= '0;
		end else begin
			done_q     <= 1'b0;
			chk_vld_s1 <= rd_en;
			chk_row_s1 <= scan_row_q;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_release_q <= req_type;
						req_run_q     <= run_kind;
						owner_q       <= owner_id;
						rel_start_q   <= start_slot;
						if (req_type == REQ_RELEASE && !row_in_range) begin
							done_q     <= 1'b1;
							granted_q  <= 1'b0;
							got_row_q  <= '0;
							got_slot_q <= '0;
							cnt_out_q  <= '0;
						end else begin
							state_q    <= ST_SCAN;
							issue_q    <= 1'b1;
							scan_row_q <= (req_type == REQ_RELEASE) ? RW'(row_index) : '0;
						end
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						scan_row_q <= scan_row_q + 1'b1;
					end
					// stop reading after the last row, after the one row of a release, or once a row is taken
					if ((issue_q && (req_release_q == REQ_RELEASE
						|| scan_row_q == RW'(SLOTS - 1)))
						|| (chk_vld_s1 && (req_release_q == REQ_RELEASE || fit_hit))) begin
						issue_q <= 1'b0;
					end
					if (chk_vld_s1) begin
						if (req_release_q == REQ_RELEASE || fit_hit) begin
							wr_row_q  <= chk_row_s1;
							wr_slot_q <= fit_slot;
							wr_occ_q  <= new_occ;
							wr_cnt_q  <= new_cnt;
							k_q       <= '0;
							state_q   <= ST_WRITE;
						end else if (chk_row_s1 == RW'(SLOTS - 1)) begin
							// no row has room
							done_q     <= 1'b1;
							granted_q  <= 1'b0;
							got_row_q  <= '0;
							got_slot_q <= '0;
							cnt_out_q  <= '0;
							state_q    <= ST_IDLE;
						end
					end
				end
				ST_WRITE: begin
					if (wr_last) begin
						done_q    <= 1'b1;
						granted_q <= 1'b1;
						got_row_q <= ROW_W'(wr_row_q);
						got_slot_q <= (req_release_q == REQ_RELEASE) ? rel_start_q
							: SLOT_W'(wr_slot_q);
						cnt_out_q <= CNT_OUT_W'(wr_cnt_q);
						state_q   <= ST_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign granted        = granted_q;
	assign got_row        = got_row_q;
	assign got_slot       = got_slot_q;
	assign row_free_count = cnt_out_q;

	`FFRSA_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`FFRSA_ASSERT_IMP(a_nogrant_zero, clk, arst_n, done && !granted,
		got_row == '0 && got_slot == '0 && row_free_count == '0)
	`FFRSA_ASSERT_NXT(a_start_taken, clk, arst_n, start && !busy, busy || done)
	`FFRSA_ASSERT_NXT(a_done_single, clk, arst_n, done, !done)
	`FFRSA_ASSERT_IMP(a_write_row_ok, clk, arst_n, row_wr_en,
		int'(wr_row_q) < SLOTS && state_q == ST_WRITE)

endmodule

@@ rtl/ffrsa_row_mem.sv @@
module ffrsa_row_mem
	import ffrsa_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [$clog2(SLOTS)-1:0]   rd_addr,
	output logic [SLOTS-1:0]           rd_occ,
	output logic [$clog2(SLOTS+1)-1:0] rd_cnt,
	input  logic                       wr_en,
	input  logic [$clog2(SLOTS)-1:0]   wr_addr,
	input  logic [SLOTS-1:0]           wr_occ,
	input  logic [$clog2(SLOTS+1)-1:0] wr_cnt
);

	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = SLOTS + CW;

	logic [EW-1:0]    row_mem_q [SLOTS];
	logic [SLOTS-1:0] row_vld_q;
	logic [EW-1:0]    rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem_q[wr_addr] <= {wr_occ, wr_cnt};
		end
		if (rd_en) begin
			rd_data_q <= row_mem_q[rd_addr];
		end
	end

	// a row never written reads as fully free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	assign rd_occ = rd_vld_q ? rd_data_q[EW-1:CW] : '0;
	assign rd_cnt = rd_vld_q ? rd_data_q[CW-1:0] : CW'(SLOTS);

endmodule

@@ rtl/ffrsa_owner_mem.sv @@
module ffrsa_owner_mem
	import ffrsa_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [ID_W-1:0]          wr_id
);

	logic [ID_W-1:0] owner_mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			owner_mem_q[wr_addr] <= wr_id;
		end
	end

endmodule

@@ rtl/ffrsa_fit.sv @@
module ffrsa_fit
	import ffrsa_pkg::*;
#(
	parameter int SLOTS      = 8,
	parameter int RUN_LENGTH = 2
) (
	input  logic [SLOTS-1:0]         occ,
	input  logic                     run_kind,
	output logic                     hit,
	output logic [$clog2(SLOTS)-1:0] slot
);

	localparam int SW = $clog2(SLOTS);

	logic [SLOTS+RUN_LENGTH-1:0] occ_pad;
	logic [SLOTS-1:0]            fit;

	// slots past the row end count as taken
	assign occ_pad = {{RUN_LENGTH{1'b1}}, occ};

	always_comb begin
		logic run_free;
		run_free = 1'b1;
		for (int s = 0; s < SLOTS; s++) begin
			run_free = 1'b1;
			for (int k = 0; k < RUN_LENGTH; k++) begin
				if (occ_pad[s+k]) begin
					run_free = 1'b0;
				end
			end
			fit[s] = (run_kind == RUN_MULTI) ? run_free : ~occ[s];
		end
	end

	// lowest start slot wins
	always_comb begin
		hit  = 1'b0;
		slot = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (fit[s]) begin
				hit  = 1'b1;
				slot = SW'(s);
			end
		end
	end

endmodule

@@ tb/first_fit_run_slot_allocator_tb.sv @@
`timescale 1ns / 1ps

module first_fit_run_slot_allocator_tb;
	import ffrsa_pkg::*;

	localparam int GRID     = 8;
	localparam int RUN_LEN  = 2;
	localparam int N_RANDOM = 1840;
	localparam int WAVE     = 150;

	typedef struct packed {
		logic                 granted;
		logic [ROW_W-1:0]     row;
		logic [SLOT_W-1:0]    slot;
		logic [CNT_OUT_W-1:0] free_cnt;
	} grant_t;

	class alloc_grid_model;
		logic [ID_W:0] owner_tab [GRID*GRID];
		int unsigned   free_cnt [GRID];
		grant_t        expected_grants [$];
		int            errors;

		function new();
			for (int i = 0; i < GRID*GRID; i++)
				owner_tab[i] = '0;
			for (int r = 0; r < GRID; r++)
				free_cnt[r] = GRID;
			errors = 0;
		endfunction

		// work out the grant for one accepted request beat and update the grid
		function void note_request(logic rt, logic rk, logic [ID_W-1:0] id,
				logic [ROW_W-1:0] row, logic [SLOT_W-1:0] slot);
			int unsigned len;
			bit          fit;
			grant_t      res;
			len = (rk == RUN_MULTI) ? RUN_LEN : 1;
			res = '0;
			if (rt == REQ_ALLOC) begin
				// rows in order, then start slots in order: first fit wins
				for (int r = 0; r < GRID && !res.granted; r++)
					for (int s = 0; s + len <= GRID && !res.granted; s++) begin
						fit = 1'b1;
						for (int k = 0; k < len; k++)
							if (owner_tab[r*GRID + s + k][ID_W])
								fit = 1'b0;
						if (fit) begin
							for (int k = 0; k < len; k++)
								owner_tab[r*GRID + s + k] = {1'b1, id};
							free_cnt[r] = (free_cnt[r] > len) ? free_cnt[r] - len : 0;
							res = '{1'b1, ROW_W'(r), SLOT_W'(s), CNT_OUT_W'(free_cnt[r])};
						end
					end
			end else if (int'(row) < GRID) begin
				// no ownership check; slots past the row end are left alone
				for (int k = 0; k < len; k++)
					if (int'(slot) + k < GRID)
						owner_tab[int'(row)*GRID + int'(slot) + k] = '0;
				free_cnt[row] = free_cnt[row] + len;
				if (free_cnt[row] > GRID)
					free_cnt[row] = GRID;
				res = '{1'b1, row, slot, CNT_OUT_W'(free_cnt[row])};
			end
			expected_grants.push_back(res);
		endfunction

		function void check_grant(grant_t got);
			grant_t exp;
			if (expected_grants.size() == 0) begin
				$error("result beat with none expected: granted %0d row %0d slot %0d count %0d",
					got.granted, got.row, got.slot, got.free_cnt);
				errors++;
				return;
			end
			exp = expected_grants.pop_front();
			if (got.granted !== exp.granted) begin
				$error("granted: expected %0d, actual %0d", exp.granted, got.granted);
				errors++;
			end
			if (got.row !== exp.row) begin
				$error("got_row: expected %0d, actual %0d", exp.row, got.row);
				errors++;
			end
			if (got.slot !== exp.slot) begin
				$error("got_slot: expected %0d, actual %0d", exp.slot, got.slot);
				errors++;
			end
			if (got.free_cnt !== exp.free_cnt) begin
				$error("row_free_count: expected %0d, actual %0d", exp.free_cnt, got.free_cnt);
				errors++;
			end
		endfunction

		// random taken slot as a flat index, -1 when the grid is empty
		function int pick_taken();
			int taken [$];
			for (int i = 0; i < GRID*GRID; i++)
				if (owner_tab[i][ID_W])
					taken.push_back(i);
			if (taken.size() == 0)
				return -1;
			return taken[$urandom_range(taken.size() - 1)];
		endfunction
	endclass

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic                 req_type   = REQ_ALLOC;
	logic                 run_kind   = RUN_SINGLE;
	logic [ID_W-1:0]      owner_id   = '0;
	logic [ROW_W-1:0]     row_index  = '0;
	logic [SLOT_W-1:0]    start_slot = '0;
	logic                 busy;
	logic                 done;
	logic                 granted;
	logic [ROW_W-1:0]     got_row;
	logic [SLOT_W-1:0]    got_slot;
	logic [CNT_OUT_W-1:0] row_free_count;

	alloc_grid_model model = new();
	int              idle_pct;
	int              alloc_pct;

	first_fit_run_slot_allocator #(
		.SLOTS      (GRID),
		.RUN_LENGTH (RUN_LEN)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.run_kind       (run_kind),
		.owner_id       (owner_id),
		.row_index      (row_index),
		.start_slot     (start_slot),
		.done           (done),
		.granted        (granted),
		.got_row        (got_row),
		.got_slot       (got_slot),
		.row_free_count (row_free_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// results cannot be held off, so every done cycle is a beat
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			model.check_grant('{granted, got_row, got_slot, row_free_count});
		end else if (arst_n && done !== 1'b0) begin
			$error("done: expected 0 or 1, actual %b", done);
			model.errors++;
		end
	end

	// drop start now and then, with junk on the fields while it is low
	task automatic idle_after();
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do begin
				req_type   <= 1'($urandom_range(1));
				run_kind   <= 1'($urandom_range(1));
				owner_id   <= ID_W'($urandom);
				row_index  <= ROW_W'($urandom);
				start_slot <= SLOT_W'($urandom);
				@(posedge clk);
			end while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic drive_beat(logic rt, logic rk, logic [ID_W-1:0] id,
			logic [ROW_W-1:0] row, logic [SLOT_W-1:0] slot);
		start      <= 1'b1;
		req_type   <= rt;
		run_kind   <= rk;
		owner_id   <= id;
		row_index  <= row;
		start_slot <= slot;
		do @(posedge clk); while (busy !== 1'b0);
		model.note_request(rt, rk, id, row, slot);
		idle_after();
	endtask

	// allocations or releases; releases mostly of real allocations, some anywhere
	task automatic random_beat();
		logic              rt;
		logic              rk;
		logic [ID_W-1:0]   id;
		logic [ROW_W-1:0]  row;
		logic [SLOT_W-1:0] slot;
		int                idx;
		rt   = ($urandom_range(99) < alloc_pct) ? REQ_ALLOC : REQ_RELEASE;
		rk   = $urandom_range(1) ? RUN_MULTI : RUN_SINGLE;
		id   = ID_W'($urandom);
		row  = ROW_W'($urandom);
		slot = SLOT_W'($urandom);
		if (rt == REQ_RELEASE && $urandom_range(3) != 0) begin
			idx = model.pick_taken();
			if (idx >= 0) begin
				row  = ROW_W'(idx / GRID);
				slot = SLOT_W'(idx % GRID);
			end
		end
		drive_beat(rt, rk, id, row, slot);
	endtask

	initial begin
		int phase;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 0;
		drive_beat(REQ_ALLOC,   RUN_SINGLE, 16'h0000, 3'd0, 3'd0);
		drive_beat(REQ_ALLOC,   RUN_MULTI,  16'hFFFF, 3'd0, 3'd0);
		drive_beat(REQ_ALLOC,   RUN_SINGLE, 16'hA5A5, 3'd7, 3'd7);
		// free half of a run, leaving a one-slot hole
		drive_beat(REQ_RELEASE, RUN_SINGLE, 16'h0000, 3'd0, 3'd1);
		drive_beat(REQ_ALLOC,   RUN_MULTI,  16'h5A5A, 3'd0, 3'd0);
		drive_beat(REQ_ALLOC,   RUN_SINGLE, 16'h1234, 3'd0, 3'd0);
		// run past the end of the row, already free, count saturates
		drive_beat(REQ_RELEASE, RUN_MULTI,  16'hFFFF, 3'd7, 3'd7);
		drive_beat(REQ_RELEASE, RUN_SINGLE, 16'h0000, 3'd3, 3'd4);
		drive_beat(REQ_RELEASE, RUN_MULTI,  16'h0000, 3'd0, 3'd6);
		drive_beat(REQ_ALLOC,   RUN_MULTI,  16'h8000, 3'd0, 3'd0);
		drive_beat(REQ_RELEASE, RUN_MULTI,  16'h7FFF, 3'd0, 3'd0);
		drive_beat(REQ_ALLOC,   RUN_MULTI,  16'h0001, 3'd7, 3'd7);
		drive_beat(REQ_RELEASE, RUN_SINGLE, 16'hFFFF, 3'd0, 3'd7);

		// alternate filling and draining waves so the grid runs full and empty
		for (int n = 0; n < N_RANDOM; n++) begin
			phase = n * 4 / N_RANDOM;
			case (phase)
				0: idle_pct = 0;
				1: idle_pct = 84;
				2: idle_pct = 9;
				default: idle_pct = 0;
			endcase
			alloc_pct = ((n / WAVE) % 2) ? 25 : 85;
			random_beat();
		end
		start <= 1'b0;

		while (model.expected_grants.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (model.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
